>>> src/dgcf_pkg.sv
// ----------------------------------------------------------------------------
// dgcf_pkg
// Shared types and constants of the follower graph block: operation codes,
// status codes, fixed field widths and the control struct of the tally unit.
// ----------------------------------------------------------------------------
package dgcf_pkg;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int NODE_W  = 5;
    localparam int CFG_W   = 6;
    localparam int CMP_W   = CFG_W + 1;
    localparam int K_W     = 6;
    localparam int CIDX_W  = 1;

    // most results one find may give
    localparam int MAX_RESULTS = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

    // status codes
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_INDEX = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_NODE_COUNT    = 1'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_FOLLOWERS = 1'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] NODE_COUNT_RST    = 6'd32;
    localparam logic [CFG_W-1:0] MIN_FOLLOWERS_RST = 6'd1;

    // control of the follower tally lanes
    typedef struct packed {
        logic clear;
        logic update;
    } tally_ctrl_t;

    // one result item
    typedef struct packed {
        logic              status;
        logic              edge_present;
        logic              found;
        logic [NODE_W-1:0] celebrity_index;
        logic              last;
    } out_item_t;

endpackage

>>> src/dgcf_row_mem.sv
// ----------------------------------------------------------------------------
// dgcf_row_mem
// Adjacency row memory: one row per follower node, one write and one
// registered read port. A valid bit per row makes unwritten rows read zero.
// ----------------------------------------------------------------------------
module dgcf_row_mem #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DEPTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DEPTH-1:0]         rdata
);

    logic [DEPTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] rd_reg;
    logic             rvalid_reg;
    logic [DEPTH-1:0] row_valid_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    // row valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                row_valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= row_valid_reg[raddr];
            end
        end
    end

    // a row never written reads as no edges
    assign rdata = rvalid_reg ? rd_reg : '0;

endmodule

>>> src/dgcf_tally.sv
// ----------------------------------------------------------------------------
// dgcf_tally
// Follower tally lanes: one follower counter and one follows-someone flag per
// node, updated from each scanned row, and the resulting celebrity vector.
// ----------------------------------------------------------------------------
module dgcf_tally #(
    parameter int N = 32
) (
    input  logic                            clk,
    input  dgcf_pkg::tally_ctrl_t           ctrl,
    input  logic [N-1:0]                    row,
    input  logic [$clog2(N)-1:0]            idx,
    input  logic [N-1:0]                    use_mask,
    input  logic [dgcf_pkg::CFG_W-1:0]      min_followers,
    output logic [N-1:0]                    cel
);
    import dgcf_pkg::*;

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg [N];
    logic [N-1:0]     out_any_reg;
    logic [N-1:0]     hit;

    // edges of the scanned row that count: nodes in use, no self-loop
    assign hit = row & use_mask & ~(N'(1) << idx);

    // lane update
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            out_any_reg <= '0;
            for (int c = 0; c < N; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else if (ctrl.update)
        begin
            out_any_reg[idx] <= |hit;
            for (int c = 0; c < N; c++)
            begin
                cnt_reg[c] <= cnt_reg[c] + CNT_W'(hit[c]);
            end
        end
    end

    // celebrity test per lane
    always_comb
    begin
        for (int c = 0; c < N; c++)
        begin
            cel[c] = use_mask[c] && !out_any_reg[c]
                     && (CMP_W'(cnt_reg[c]) >= CMP_W'(min_followers));
        end
    end

endmodule

>>> src/directed_graph_celebrity_finder.sv
// ----------------------------------------------------------------------------
// directed_graph_celebrity_finder
// Directed follower graph in an adjacency row memory with edge insert,
// remove, query and a celebrity search.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (op, from_node, to_node) enter on in_valid/in_stall; result
//   items leave on out_valid/out_stall through one output register.
//   Configuration (node_count, min_followers) is written on cfg_we with
//   cfg_index and cfg_data; the user must write it only while the block is
//   idle, the block itself does not enforce this. Edge operations are a
//   read-modify-write of one row and give one result with last set.
//   A find reads rows 0..n-1 once, one per cycle, into per-node tally
//   lanes, n being the nodes in use, judges them in S_JUDGE, then walks
//   candidates one index per cycle, waiting at a celebrity while the
//   output register is stalled, and emits each celebrity; it gives one
//   not-found item when nothing qualifies.
//   in_stall is high while an item is at work; a stalled output register
//   holds its item and the block waits before loading the next result.
//   Reset clears the graph (row valid bits) and loads node_count 32 and
//   min_followers 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module directed_graph_celebrity_finder #(
    parameter int MAX_NODES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [dgcf_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [dgcf_pkg::CFG_W-1:0]    cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dgcf_pkg::OP_W-1:0]     op,
    input  logic [dgcf_pkg::NODE_W-1:0]   from_node,
    input  logic [dgcf_pkg::NODE_W-1:0]   to_node,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic                          edge_present,
    output logic                          found,
    output logic [dgcf_pkg::NODE_W-1:0]   celebrity_index,
    output logic                          last
);
    import dgcf_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int N_W   = $clog2(MAX_NODES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_JUDGE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CFG_W-1:0]     node_count_reg;
    logic [CFG_W-1:0]     min_followers_reg;

    logic [OP_W-1:0]      op_reg;
    logic [NODE_W-1:0]    from_reg;
    logic [NODE_W-1:0]    to_reg;
    logic                 err_reg;

    logic [N_W-1:0]       issue_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_idx_reg;

    logic [MAX_NODES-1:0] cel_reg;
    logic [IDX_W-1:0]     emit_idx_reg;
    logic [K_W-1:0]       emit_k_reg;

    out_item_t            out_reg, out_next;
    logic                 out_valid_reg;
    logic                 out_load;
    logic                 out_free;

    logic [N_W-1:0]       n_eff;
    logic [MAX_NODES-1:0] use_mask;
    logic                 in_accept;
    logic                 in_err;

    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;
    logic [MAX_NODES-1:0] mem_wdata, mem_rdata;
    logic [MAX_NODES-1:0] to_bit;

    tally_ctrl_t          tally_ctrl;
    logic [MAX_NODES-1:0] cel;

    logic                 scan_issue;
    logic                 scan_done;
    logic [MAX_NODES-1:0] cel_rest;
    logic                 emit_last;

    // nodes in use, saturated to the storage size
    assign n_eff = ({1'b0, node_count_reg} > CMP_W'(MAX_NODES))
                   ? N_W'(MAX_NODES) : N_W'(node_count_reg);

    always_comb
    begin
        for (int c = 0; c < MAX_NODES; c++)
        begin
            use_mask[c] = CMP_W'(c) < CMP_W'(n_eff);
        end
    end

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_err    = (CMP_W'(from_node) >= CMP_W'(n_eff))
                       || (CMP_W'(to_node) >= CMP_W'(n_eff));
    assign out_free  = !out_valid_reg || !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg    <= NODE_COUNT_RST;
            min_followers_reg <= MIN_FOLLOWERS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:    node_count_reg    <= cfg_data;
                REG_MIN_FOLLOWERS: min_followers_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // scan and emit helpers
    assign scan_issue = (state_reg == S_SCAN) && (CMP_W'(issue_reg) < CMP_W'(n_eff));
    assign scan_done  = pend_reg && (CMP_W'(pend_idx_reg) + CMP_W'(1) == CMP_W'(n_eff));
    assign cel_rest   = cel_reg & ~(MAX_NODES'(1) << emit_idx_reg);
    assign emit_last  = (cel_rest == '0) || (emit_k_reg == K_W'(MAX_RESULTS - 1));
    assign to_bit     = MAX_NODES'(1) << to_reg;

    // memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = IDX_W'(from_node);
        if (in_accept && op != OP_FIND && !in_err)
        begin
            mem_re = 1'b1;
        end
        else if (scan_issue)
        begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(issue_reg);
        end
    end

    assign mem_waddr = IDX_W'(from_reg);
    assign mem_wdata = (op_reg == OP_INSERT) ? (mem_rdata | to_bit)
                                             : (mem_rdata & ~to_bit);

    // sequencer and result selection
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        out_next   = '0;
        out_next.last = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op != OP_FIND)
                    begin
                        state_next = S_EDGE;
                    end
                    else if (n_eff == '0)
                    begin
                        state_next = S_JUDGE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_EDGE:
            begin
                out_next.status       = err_reg ? ST_BAD_INDEX : ST_OK;
                out_next.edge_present = !err_reg && (op_reg == OP_QUERY)
                                        && mem_rdata[IDX_W'(to_reg)];
                if (out_free)
                begin
                    out_load   = 1'b1;
                    mem_we     = !err_reg && (op_reg == OP_INSERT || op_reg == OP_REMOVE);
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cel_reg == '0)
                begin
                    // no celebrity: single not-found item
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (cel_reg[emit_idx_reg])
                begin
                    out_next.found           = 1'b1;
                    out_next.celebrity_index = NODE_W'(emit_idx_reg);
                    out_next.last            = emit_last;
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            issue_reg     <= '0;
            emit_k_reg    <= '0;
            emit_idx_reg  <= '0;
            cel_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // scan pipeline
            if (in_accept)
            begin
                issue_reg <= '0;
                pend_reg  <= 1'b0;
            end
            else
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    issue_reg <= issue_reg + N_W'(1);
                end
            end

            // emit walk
            if (state_reg == S_JUDGE)
            begin
                cel_reg      <= cel;
                emit_idx_reg <= '0;
                emit_k_reg   <= '0;
            end
            else if (state_reg == S_EMIT && cel_reg != '0)
            begin
                if (cel_reg[emit_idx_reg])
                begin
                    if (out_free)
                    begin
                        cel_reg      <= cel_rest;
                        emit_k_reg   <= emit_k_reg + K_W'(1);
                        emit_idx_reg <= emit_idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    emit_idx_reg <= emit_idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // item and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op;
            from_reg <= from_node;
            to_reg   <= to_node;
            err_reg  <= in_err;
        end
        if (scan_issue)
        begin
            pend_idx_reg <= IDX_W'(issue_reg);
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign tally_ctrl.clear  = in_accept;
    assign tally_ctrl.update = pend_reg && (state_reg == S_SCAN);

    dgcf_row_mem #(
        .DEPTH (MAX_NODES)
    ) u_row_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dgcf_tally #(
        .N (MAX_NODES)
    ) u_tally (
        .clk           (clk),
        .ctrl          (tally_ctrl),
        .row           (mem_rdata),
        .idx           (pend_idx_reg),
        .use_mask      (use_mask),
        .min_followers (min_followers_reg),
        .cel           (cel)
    );

    // output ports
    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign edge_present    = out_reg.edge_present;
    assign found           = out_reg.found;
    assign celebrity_index = out_reg.celebrity_index;
    assign last            = out_reg.last;

    // a row is written back only by an in-range insert or remove
    a_write_only_edge: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EDGE && !err_reg && out_load))
        else $error("row write outside an edge operation");

    // a new result never overwrites one that is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

    // the scan never reads past the nodes in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CMP_W'(issue_reg) <= CMP_W'(n_eff)))
        else $error("scan issued past node count");

    // a find never gives more than the result limit
    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_k_reg < K_W'(MAX_RESULTS)))
        else $error("too many find results");

    // an accepted edge item goes to the read-modify-write step
    a_edge_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op != OP_FIND) |=> (state_reg == S_EDGE))
        else $error("edge item not executed");

endmodule
